// ===== rtl/rakeh_pkg.sv =====
// shared types, constants and decode helpers for the rom access key event hold block
package rakeh_pkg;

    localparam int BITMAP_W = 128;
    localparam int HALF_W   = 64;

    localparam logic [15:0] KEY_BASE   = 16'h9000;
    localparam logic [15:0] KEY_MASK   = 16'hFF80;
    localparam logic [15:0] KEY_BITS   = 16'h007F;
    localparam logic [7:0]  HOLD_RESET = 8'd20;
    localparam logic [15:0] ADDR_TICK  = 16'hDCBA;
    localparam logic [15:0] ADDR_START = 16'hE1A8;
    localparam logic [15:0] ADDR_EXIT  = 16'hABCD;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_TICK  = 3'd1;
    localparam logic [2:0] EV_START = 3'd2;
    localparam logic [2:0] EV_EXIT  = 3'd3;
    localparam logic [2:0] EV_KEY   = 3'd4;

    localparam logic REQ_BUS   = 1'b0;
    localparam logic REQ_MERGE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] access_addr;
        logic        rom_window_hit;
        logic [63:0] host_keys_low;
        logic [63:0] host_keys_high;
    } rakeh_in_t;

    typedef struct packed {
        logic [2:0]  event_code;
        logic        bitmap_valid;
        logic [63:0] merged_keys_low;
        logic [63:0] merged_keys_high;
    } rakeh_out_t;

    function automatic logic is_key_addr(input logic [15:0] addr);
        return (addr & KEY_MASK) == KEY_BASE;
    endfunction

    // event for a host bus access
    function automatic logic [2:0] decode_event(input logic [15:0] addr, input logic hit);
        logic [2:0] ev;
        ev = EV_NONE;
        if (hit) begin
            if (is_key_addr(addr)) begin
                ev = EV_KEY;
            end else if (addr == ADDR_TICK) begin
                ev = EV_TICK;
            end else if (addr == ADDR_START) begin
                ev = EV_START;
            end else if (addr == ADDR_EXIT) begin
                ev = EV_EXIT;
            end
        end
        return ev;
    endfunction

endpackage

// ===== rtl/rakeh_mem.sv =====
// hold counter memory with one write and one registered read port, per-entry valid bits
module rakeh_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [7:0]       mem_q_reg;
    logic             vld_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                vld_q_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = vld_q_reg ? mem_q_reg : 8'd0;

endmodule

// ===== rtl/rom_access_key_event_hold.sv =====
// top level: access decoder, counter walk sequencer and result buffering
//
// Input channel s_valid/s_ready/s_data carries one request: a host bus access
// (req_type 0) or a frame-tick merge request (req_type 1). Every request gives
// exactly one result on m_valid/m_ready/m_data.
// A bus access is decoded in the accept cycle; a key address loads the hold
// counter of its scancode, and the result is registered into the output
// register, or into the holding buffer if the output stalls. A merge request
// walks the hold counter memory one entry per cycle through its single read
// port, with the decrement written back on the write port in the following
// cycle; the result forms in the drain state, then a new request is taken.
// A finished result that the receiver stalls goes into a one-entry holding
// buffer, so one more bus access can be accepted; s_ready drops while that
// buffer is full or a walk is running.
// The hold_frames register is written through cfg_valid/cfg_ready/cfg_data
// (always ready) and resets to 20. Reset clears all hold counters at once
// through per-entry valid bits, so no clearing pass is needed.
module rom_access_key_event_hold #(
    parameter int NUM_SCANCODES = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rakeh_pkg::rakeh_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rakeh_pkg::rakeh_out_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data
);

    localparam int AW = $clog2(NUM_SCANCODES);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SCANCODES - 1);
    localparam logic [7:0]    NUM_8    = 8'(NUM_SCANCODES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    state_t                         state_reg, state_next;
    logic [AW-1:0]                  cnt_reg, cnt_next;
    logic                           rv_reg, rv_next;
    logic [AW-1:0]                  ridx_reg, ridx_next;
    logic [rakeh_pkg::BITMAP_W-1:0] bm_reg, bm_next;
    logic [7:0]                     hold_reg, hold_next;
    logic                           m_valid_reg, m_valid_next;
    rakeh_pkg::rakeh_out_t          m_data_reg, m_data_next;
    logic                           pend_reg, pend_next;
    rakeh_pkg::rakeh_out_t          pend_data_reg, pend_data_next;

    logic                           s_fire;
    logic                           bus_fire;
    logic                           key_wr;
    logic [6:0]                     key_sc;
    logic                           ret_hit;
    logic [7:0]                     rd_data;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [7:0]                     wr_data;
    logic                           rd_en;
    logic [rakeh_pkg::BITMAP_W-1:0] bm_merged;
    logic                           done;
    rakeh_pkg::rakeh_out_t          res;
    logic                           out_free;

    assign s_ready   = (state_reg == ST_IDLE) && !pend_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign s_fire   = s_valid && s_ready;
    assign bus_fire = s_fire && (s_data.req_type == rakeh_pkg::REQ_BUS);
    assign key_sc   = 7'(s_data.access_addr & rakeh_pkg::KEY_BITS);
    assign key_wr   = bus_fire && s_data.rom_window_hit
                      && rakeh_pkg::is_key_addr(s_data.access_addr)
                      && ({1'b0, key_sc} < NUM_8);

    // returned counter from the entry read last cycle
    assign ret_hit = rv_reg && (rd_data != 8'd0);

    assign wr_en   = key_wr || ret_hit;
    assign wr_addr = ret_hit ? ridx_reg : key_sc[AW-1:0];
    assign wr_data = ret_hit ? (rd_data - 8'd1) : hold_reg;
    assign rd_en   = (state_reg == ST_WALK);

    assign bm_merged = ret_hit
        ? (bm_reg | (rakeh_pkg::BITMAP_W'(1) << ridx_reg))
        : bm_reg;

    assign done     = bus_fire || (state_reg == ST_DRAIN);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        res = '0;
        if (state_reg == ST_DRAIN) begin
            res.event_code       = rakeh_pkg::EV_NONE;
            res.bitmap_valid     = 1'b1;
            res.merged_keys_low  = bm_merged[rakeh_pkg::HALF_W-1:0];
            res.merged_keys_high = bm_merged[rakeh_pkg::BITMAP_W-1:rakeh_pkg::HALF_W];
        end else begin
            res.event_code = rakeh_pkg::decode_event(s_data.access_addr,
                                                     s_data.rom_window_hit);
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rv_next        = 1'b0;
        ridx_next      = ridx_reg;
        bm_next        = bm_reg;
        hold_next      = hold_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        pend_next      = pend_reg;
        pend_data_next = pend_data_reg;

        if (cfg_valid && cfg_ready) begin
            hold_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.req_type == rakeh_pkg::REQ_MERGE)) begin
                    bm_next    = {s_data.host_keys_high, s_data.host_keys_low};
                    cnt_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                bm_next   = bm_merged;
                rv_next   = 1'b1;
                ridx_next = cnt_reg;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a new result can only finish while the holding buffer is empty
        if (out_free) begin
            if (pend_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = pend_data_reg;
                pend_next    = 1'b0;
            end else begin
                m_valid_next = done;
                if (done) begin
                    m_data_next = res;
                end
            end
        end else if (done) begin
            pend_next      = 1'b1;
            pend_data_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rv_reg      <= 1'b0;
            hold_reg    <= rakeh_pkg::HOLD_RESET;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rv_reg      <= rv_next;
            hold_reg    <= hold_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
        ridx_reg      <= ridx_next;
        bm_reg        <= bm_next;
        m_data_reg    <= m_data_next;
        pend_data_reg <= pend_data_next;
    end

    rakeh_mem #(
        .DEPTH (NUM_SCANCODES),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

endmodule

// ===== rtl/rakeh_checker.sv =====
// port-level checks for the rom access key event hold block, bound to the top level
module rakeh_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input rakeh_pkg::rakeh_in_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input rakeh_pkg::rakeh_out_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // bus access results carry no bitmap
    a_bus_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.bitmap_valid |->
            m_data.merged_keys_low == 64'd0 && m_data.merged_keys_high == 64'd0)
        else $error("bus access result carries bitmap bits");

    // merge results never carry an event
    a_merge_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bitmap_valid |-> m_data.event_code == rakeh_pkg::EV_NONE)
        else $error("merge result carries an event code");

    // a bus access with a free output shows its result on the next cycle
    a_bus_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.req_type == rakeh_pkg::REQ_BUS && !m_valid
            |=> m_valid)
        else $error("bus access result late");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rom_access_key_event_hold rakeh_checker u_rakeh_checker (.*);
